@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL top level
// Clocked property checks on aclk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check at every aclk edge while out of reset
`define PIPB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check at every aclk edge, reset included
`define PIPB_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/pipb_pkg.sv @@
// ----------------------------------------------------------------------------
// pipb_pkg
// Types, constants and Q16.16 helpers for the particle step pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pipb_pkg;

    localparam int IN_DATA_W      = 328;
    localparam int OUT_DATA_W     = 296;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 17;
    localparam int HIT_W          = 4;
    localparam int MAX_PLANES_DEF = 8;

    // Q16.16 constants; VMAX_SQ is Q32.32
    localparam logic signed [31:0] Q_GRAVITY = 32'sd642908;
    localparam logic [20:0]        Q_VMAX    = 21'd1638400;
    localparam logic signed [31:0] Q_EPS     = 32'sd7;
    localparam logic signed [31:0] Q_DAMP    = 32'sd58982;
    localparam logic [63:0]        VMAX_SQ   = 64'd2684354560000;

    localparam logic [16:0] STEP_TIME_RST   = 17'd1092;
    localparam logic [3:0]  PLANE_COUNT_RST = 4'd0;

    // speed clamp: square root and divider
    localparam int SQ_BITS    = 2;
    localparam int SQ_STAGES  = 32 / SQ_BITS;
    localparam int NUM_W      = 52;
    localparam int QUO_W      = 21;
    localparam int DIV_BITS   = 3;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_TIME   = 2'd0,
        CFG_GRAVITY     = 2'd1,
        CFG_PLANES      = 2'd2,
        CFG_PLANE_COUNT = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_PARTICLE = 1'b0,
        REQ_PLANE    = 1'b1
    } req_t;

    typedef logic signed [31:0] q_t;
    typedef logic signed [47:0] prod_t;
    typedef q_t [2:0] vec3_t;

    typedef struct packed {
        logic        vld;
        logic        ld;
        logic [2:0]  slot;
        vec3_t       p;
        vec3_t       v;
        vec3_t       a;
        logic [30:0] rad;
    } item_t;

    typedef struct packed {
        item_t            it;
        logic [HIT_W-1:0] hits;
    } pl_item_t;

    function automatic logic signed [63:0] sx64(input q_t x);
        logic signed [63:0] r;
        r = x;
        return r;
    endfunction

    function automatic logic signed [63:0] px64(input prod_t x);
        logic signed [63:0] r;
        r = x;
        return r;
    endfunction

    function automatic q_t sat32(input logic signed [63:0] x);
        q_t r;
        if (x > $signed(64'h0000_0000_7FFF_FFFF)) begin
            r = 32'h7FFF_FFFF;
        end else if (x < $signed(64'hFFFF_FFFF_8000_0000)) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // rounded Q16.16 product, ties up
    function automatic prod_t mulr(input q_t a, input q_t b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        logic signed [63:0] pr;
        ea = a;
        eb = b;
        pr = ea * eb + 64'sd32768;
        pr = pr >>> 16;
        return prod_t'(pr);
    endfunction

endpackage

`default_nettype wire

@@ src/pipb_clamp.sv @@
// ----------------------------------------------------------------------------
// pipb_clamp
// Speed clamp: squared length, pipelined square root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pipb_clamp (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire pipb_pkg::item_t in_item,
    output pipb_pkg::item_t      out_item
);

    localparam int SQS = pipb_pkg::SQ_STAGES;
    localparam int DVS = pipb_pkg::DIV_STAGES;
    localparam int NW  = pipb_pkg::NUM_W;
    localparam int QW  = pipb_pkg::QUO_W;

    // squares and scaled magnitudes
    pipb_pkg::item_t d_item_reg;
    logic [62:0]     d_sq_reg  [3];
    logic [NW-1:0]   d_num_reg [3];

    // square root pipeline, entry 0 is the summing stage
    pipb_pkg::item_t sq_item_reg [SQS+1];
    logic [63:0]     sq_lsq_reg  [SQS+1];
    logic [35:0]     sq_rem_reg  [SQS+1];
    logic [31:0]     sq_root_reg [SQS+1];
    logic [NW-1:0]   sq_num_reg  [SQS+1][3];
    logic            sq_big_reg  [SQS+1];

    // divider pipeline
    pipb_pkg::item_t dv_item_reg [DVS+1];
    logic [31:0]     dv_len_reg  [DVS+1];
    logic [NW-1:0]   dv_rem_reg  [DVS+1][3];
    logic [QW-1:0]   dv_quo_reg  [DVS+1][3];
    logic            dv_big_reg  [DVS+1];

    pipb_pkg::item_t out_reg;
    pipb_pkg::item_t out_next;

    logic [31:0]   absv     [3];
    logic [63:0]   lsq_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            absv[i] = in_item.v[i][31] ? (32'd0 - in_item.v[i]) : in_item.v[i];
        end
        lsq_next = 64'(d_sq_reg[0]) + 64'(d_sq_reg[1]) + 64'(d_sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_item_reg.vld     <= 1'b0;
            sq_item_reg[0].vld <= 1'b0;
        end else if (en) begin
            d_item_reg <= in_item;
            for (int i = 0; i < 3; i++) begin
                d_sq_reg[i]  <= 63'(64'(absv[i]) * 64'(absv[i]));
                d_num_reg[i] <= NW'(64'(absv[i]) * 64'(pipb_pkg::Q_VMAX));
            end
            sq_item_reg[0] <= d_item_reg;
            sq_lsq_reg[0]  <= lsq_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_num_reg[0]  <= d_num_reg;
            sq_big_reg[0]  <= !d_item_reg.ld && (lsq_next > pipb_pkg::VMAX_SQ);
        end
    end

    for (genvar k = 0; k < SQS; k++) begin : g_sqrt
        logic [35:0] rem_next;
        logic [31:0] root_next;

        always_comb begin : c_step
            logic [35:0] r;
            logic [35:0] t;
            logic [31:0] q;
            r = sq_rem_reg[k];
            q = sq_root_reg[k];
            for (int b = 0; b < pipb_pkg::SQ_BITS; b++) begin
                r = {r[33:0], sq_lsq_reg[k][63-2*(pipb_pkg::SQ_BITS*k+b) -: 2]};
                t = {2'b00, q, 2'b01};
                if (r >= t) begin
                    r = r - t;
                    q = {q[30:0], 1'b1};
                end else begin
                    q = {q[30:0], 1'b0};
                end
            end
            rem_next  = r;
            root_next = q;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_item_reg[k+1].vld <= 1'b0;
            end else if (en) begin
                sq_item_reg[k+1] <= sq_item_reg[k];
                sq_lsq_reg[k+1]  <= sq_lsq_reg[k];
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
                sq_num_reg[k+1]  <= sq_num_reg[k];
                sq_big_reg[k+1]  <= sq_big_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_item_reg[0].vld <= 1'b0;
        end else if (en) begin
            dv_item_reg[0] <= sq_item_reg[SQS];
            dv_len_reg[0]  <= sq_root_reg[SQS];
            dv_rem_reg[0]  <= sq_num_reg[SQS];
            for (int i = 0; i < 3; i++) begin
                dv_quo_reg[0][i] <= '0;
            end
            dv_big_reg[0]  <= sq_big_reg[SQS];
        end
    end

    // restoring division, most significant quotient bits first
    for (genvar k = 0; k < DVS; k++) begin : g_div
        logic [NW-1:0] rem_next [3];
        logic [QW-1:0] quo_next [3];

        always_comb begin : c_step
            logic [NW:0]   r;
            logic [NW:0]   dv;
            logic [QW-1:0] q;
            for (int i = 0; i < 3; i++) begin
                r = {1'b0, dv_rem_reg[k][i]};
                q = dv_quo_reg[k][i];
                for (int b = 0; b < pipb_pkg::DIV_BITS; b++) begin
                    dv = (NW+1)'(dv_len_reg[k]) << (QW - 1 - pipb_pkg::DIV_BITS*k - b);
                    if (r >= dv) begin
                        r = r - dv;
                        q[QW - 1 - pipb_pkg::DIV_BITS*k - b] = 1'b1;
                    end
                end
                rem_next[i] = r[NW-1:0];
                quo_next[i] = q;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_item_reg[k+1].vld <= 1'b0;
            end else if (en) begin
                dv_item_reg[k+1] <= dv_item_reg[k];
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_rem_reg[k+1]  <= rem_next;
                dv_quo_reg[k+1]  <= quo_next;
                dv_big_reg[k+1]  <= dv_big_reg[k];
            end
        end
    end

    always_comb begin
        logic [31:0] mag;
        out_next = dv_item_reg[DVS];
        for (int i = 0; i < 3; i++) begin
            mag = {{(32-QW){1'b0}}, dv_quo_reg[DVS][i]};
            if (dv_big_reg[DVS]) begin
                out_next.v[i] = dv_item_reg[DVS].v[i][31] ? (32'd0 - mag) : mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

@@ src/pipb_plane.sv @@
// ----------------------------------------------------------------------------
// pipb_plane
// One plane slot: stored plane, distance test, push-out and bounce.
// ----------------------------------------------------------------------------
`default_nettype none

module pipb_plane #(
    parameter int IDX = 0
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               test_en,
    input  wire pipb_pkg::pl_item_t in_item,
    output pipb_pkg::pl_item_t      out_item
);

    // stored plane; a load writes it as it passes, so order with particles holds
    pipb_pkg::vec3_t pt_reg;
    pipb_pkg::vec3_t nm_reg;

    pipb_pkg::pl_item_t a1_reg, a2_reg, a3_reg, a4_reg, a5_reg;
    logic               t1_reg, t2_reg, hit3_reg, hit4_reg;
    pipb_pkg::vec3_t    d1_reg, n1_reg, n2_reg, n3_reg, vr4_reg;
    pipb_pkg::prod_t    kv1_reg [3];
    pipb_pkg::prod_t    nd2_reg [3];
    pipb_pkg::prod_t    kn3_reg [3];
    pipb_pkg::prod_t    pm4_reg [3];
    pipb_pkg::q_t       k2_reg, move3_reg;

    pipb_pkg::q_t       dot_v, pl_dist, rad_s;
    logic               hit_next;
    pipb_pkg::pl_item_t a5_next;

    always_comb begin
        dot_v = pipb_pkg::sat32(pipb_pkg::px64(kv1_reg[0]) + pipb_pkg::px64(kv1_reg[1])
                                + pipb_pkg::px64(kv1_reg[2]));
        pl_dist = pipb_pkg::sat32(pipb_pkg::px64(nd2_reg[0]) + pipb_pkg::px64(nd2_reg[1])
                                  + pipb_pkg::px64(nd2_reg[2]));
        rad_s    = {1'b0, a2_reg.it.rad};
        hit_next = t2_reg && (pl_dist < rad_s);
    end

    always_comb begin
        a5_next = a4_reg;
        if (hit4_reg) begin
            for (int i = 0; i < 3; i++) begin
                a5_next.it.p[i] = pipb_pkg::sat32(pipb_pkg::sx64(a4_reg.it.p[i])
                                                  + pipb_pkg::px64(pm4_reg[i]));
                a5_next.it.v[i] = pipb_pkg::sat32(pipb_pkg::px64(
                                      pipb_pkg::mulr(vr4_reg[i], pipb_pkg::Q_DAMP)));
            end
            if (a4_reg.hits != '1) begin
                a5_next.hits = a4_reg.hits + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_item.it.vld && in_item.it.ld && 32'(in_item.it.slot) == IDX) begin
            pt_reg <= in_item.it.p;
            nm_reg <= in_item.it.v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_reg.it.vld <= 1'b0;
            a2_reg.it.vld <= 1'b0;
            a3_reg.it.vld <= 1'b0;
            a4_reg.it.vld <= 1'b0;
            a5_reg.it.vld <= 1'b0;
        end else if (en) begin
            // distance vector and v.n products
            a1_reg <= in_item;
            t1_reg <= test_en && in_item.it.vld && !in_item.it.ld;
            n1_reg <= nm_reg;
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]  <= pipb_pkg::sat32(pipb_pkg::sx64(in_item.it.p[i])
                                              - pipb_pkg::sx64(pt_reg[i]));
                kv1_reg[i] <= pipb_pkg::mulr(in_item.it.v[i], nm_reg[i]);
            end
            // n.d products, reflection factor
            a2_reg <= a1_reg;
            t2_reg <= t1_reg;
            n2_reg <= n1_reg;
            k2_reg <= pipb_pkg::sat32(pipb_pkg::sx64(dot_v) <<< 1);
            for (int i = 0; i < 3; i++) begin
                nd2_reg[i] <= pipb_pkg::mulr(n1_reg[i], d1_reg[i]);
            end
            // hit decision, push distance
            a3_reg    <= a2_reg;
            hit3_reg  <= hit_next;
            n3_reg    <= n2_reg;
            move3_reg <= pipb_pkg::sat32(pipb_pkg::sx64(rad_s) - pipb_pkg::sx64(pl_dist)
                                         + pipb_pkg::sx64(pipb_pkg::Q_EPS));
            for (int i = 0; i < 3; i++) begin
                kn3_reg[i] <= pipb_pkg::mulr(k2_reg, n2_reg[i]);
            end
            // push vector, reflected velocity
            a4_reg   <= a3_reg;
            hit4_reg <= hit3_reg;
            for (int i = 0; i < 3; i++) begin
                pm4_reg[i] <= pipb_pkg::mulr(n3_reg[i], move3_reg);
                vr4_reg[i] <= pipb_pkg::sat32(pipb_pkg::sx64(a3_reg.it.v[i])
                                              - pipb_pkg::px64(kn3_reg[i]));
            end
            a5_reg <= a5_next;
        end
    end

    assign out_item = a5_reg;

endmodule

`default_nettype wire

@@ src/particle_integrate_plane_bounce.sv @@
// ----------------------------------------------------------------------------
// particle_integrate_plane_bounce: Q16.16 particle step with plane bounce
// Throughput one item per cycle; the whole pipeline holds while a result waits.
// Plane loads ride the pipeline, write their slot in passing, give no result.
// Reset (aresetn low, synchronous) clears valid bits and config registers; not planes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module particle_integrate_plane_bounce #(
    parameter int MAX_PLANES = pipb_pkg::MAX_PLANES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // plane_slot, pos_x/y/z, vel_x/y/z, acc_x/y/z, radius, zero pad
    input  wire logic [pipb_pkg::IN_DATA_W-1:0]      s_tdata,
    // req_type
    input  wire logic [0:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // new_pos_x/y/z, new_vel_x/y/z, new_acc_x/y/z, planes_hit, zero pad
    output logic [pipb_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [pipb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pipb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic en;

    logic [16:0]     step_time_reg;
    logic            grav_en_reg;
    logic            planes_en_reg;
    logic [3:0]      plane_count_reg;
    pipb_pkg::q_t    dt_q;
    pipb_pkg::prod_t gdt_reg;

    pipb_pkg::item_t s0_reg, s0_next;
    pipb_pkg::item_t s1_reg, s1_next;
    pipb_pkg::item_t s2_reg;
    pipb_pkg::item_t s3_reg, s3_next;
    pipb_pkg::prod_t av_reg [3];
    pipb_pkg::item_t cl_item;
    pipb_pkg::item_t pv_item_reg;
    pipb_pkg::prod_t pv_reg [3];
    pipb_pkg::item_t pp_reg, pp_next;

    pipb_pkg::pl_item_t chain [MAX_PLANES+1];

    logic                              m_tvalid_reg;
    logic [pipb_pkg::OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign dt_q     = {15'b0, step_time_reg};

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg   <= pipb_pkg::STEP_TIME_RST;
            grav_en_reg     <= 1'b1;
            planes_en_reg   <= 1'b1;
            plane_count_reg <= pipb_pkg::PLANE_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                pipb_pkg::CFG_STEP_TIME:   step_time_reg   <= cfg_wdata;
                pipb_pkg::CFG_GRAVITY:     grav_en_reg     <= cfg_wdata[0];
                pipb_pkg::CFG_PLANES:      planes_en_reg   <= cfg_wdata[0];
                pipb_pkg::CFG_PLANE_COUNT: plane_count_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // gravity decrement per step follows step_time
    always_ff @(posedge aclk) begin
        gdt_reg <= pipb_pkg::mulr(pipb_pkg::Q_GRAVITY, dt_q);
    end

    always_comb begin
        s0_next.vld  = s_tvalid;
        s0_next.ld   = (s_tuser[0] == pipb_pkg::REQ_PLANE);
        s0_next.slot = s_tdata[2:0];
        for (int i = 0; i < 3; i++) begin
            s0_next.p[i] = s_tdata[3 + 32*i +: 32];
            s0_next.v[i] = s_tdata[99 + 32*i +: 32];
            s0_next.a[i] = s_tdata[195 + 32*i +: 32];
        end
        s0_next.rad = s_tdata[291 +: 31];

        s1_next = s0_reg;
        if (grav_en_reg && !s0_reg.ld) begin
            s1_next.a[1] = pipb_pkg::sat32(pipb_pkg::sx64(s0_reg.a[1])
                                           - pipb_pkg::px64(gdt_reg));
        end

        s3_next = s2_reg;
        if (grav_en_reg && !s2_reg.ld) begin
            for (int i = 0; i < 3; i++) begin
                s3_next.v[i] = pipb_pkg::sat32(pipb_pkg::sx64(s2_reg.v[i])
                                               + pipb_pkg::px64(av_reg[i]));
            end
        end

        pp_next = pv_item_reg;
        if (!pv_item_reg.ld) begin
            for (int i = 0; i < 3; i++) begin
                pp_next.p[i] = pipb_pkg::sat32(pipb_pkg::sx64(pv_item_reg.p[i])
                                               + pipb_pkg::px64(pv_reg[i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_reg.vld      <= 1'b0;
            s1_reg.vld      <= 1'b0;
            s2_reg.vld      <= 1'b0;
            s3_reg.vld      <= 1'b0;
            pv_item_reg.vld <= 1'b0;
            pp_reg.vld      <= 1'b0;
        end else if (en) begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            for (int i = 0; i < 3; i++) begin
                av_reg[i] <= pipb_pkg::mulr(s1_reg.a[i], dt_q);
            end
            s3_reg      <= s3_next;
            pv_item_reg <= cl_item;
            for (int i = 0; i < 3; i++) begin
                pv_reg[i] <= pipb_pkg::mulr(cl_item.v[i], dt_q);
            end
            pp_reg <= pp_next;
        end
    end

    pipb_clamp u_clamp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_item  (s3_reg),
        .out_item (cl_item)
    );

    assign chain[0] = '{it: pp_reg, hits: '0};

    for (genvar j = 0; j < MAX_PLANES; j++) begin : g_plane
        logic test_en;
        assign test_en = planes_en_reg && (5'(plane_count_reg) > 5'(j));

        pipb_plane #(
            .IDX (j)
        ) u_plane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .test_en  (test_en),
            .in_item  (chain[j]),
            .out_item (chain[j+1])
        );
    end

    always_comb begin
        m_tdata_next = '0;
        for (int i = 0; i < 3; i++) begin
            m_tdata_next[32*i +: 32]       = chain[MAX_PLANES].it.p[i];
            m_tdata_next[96 + 32*i +: 32]  = chain[MAX_PLANES].it.v[i];
            m_tdata_next[192 + 32*i +: 32] = chain[MAX_PLANES].it.a[i];
        end
        m_tdata_next[288 +: pipb_pkg::HIT_W] = chain[MAX_PLANES].hits;
    end

    // plane loads end here without a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= chain[MAX_PLANES].it.vld && !chain[MAX_PLANES].it.ld;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    `PIPB_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid_reg, "result valid after reset")
    `PIPB_ASSERT(a_hits_off, m_tvalid_reg && !planes_en_reg |-> m_tdata_reg[291:288] == 4'd0, "hits with planes off")
    `PIPB_ASSERT(a_hits_count, m_tvalid_reg |-> m_tdata_reg[291:288] <= plane_count_reg, "hits above plane count")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for particle_integrate_plane_bounce
// Loads plane tables, sends directed and random particles under several
// register settings with random gaps and stalls on both streams, and checks
// every result field against a bit-exact Q16.16 step predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int ONE       = 65536;
    localparam int WDOG_MAX  = 3000;
    localparam int DRAIN_CYC = 100;

    localparam pipb_pkg::req_t REQ_LD = pipb_pkg::REQ_PLANE;
    localparam pipb_pkg::req_t REQ_PT = pipb_pkg::REQ_PARTICLE;

    typedef struct packed {
        pipb_pkg::req_t  kind;
        logic [2:0]      slot;
        pipb_pkg::vec3_t p;
        pipb_pkg::vec3_t v;
        pipb_pkg::vec3_t a;
        logic [30:0]     rad;
    } req_item_t;

    typedef struct packed {
        logic [287:0]               pva;   // pos x/y/z, vel x/y/z, acc x/y/z from bit 0
        logic [pipb_pkg::HIT_W-1:0] hits;
    } step_res_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pipb_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [pipb_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_we = 1'b0;
    logic [pipb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pipb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow registers and plane table
    longint    dt_q = 1092;
    bit        grav_on = 1'b1;
    bit        planes_on = 1'b1;
    int        planes_used = 0;
    longint    plane_pt[8][3];
    longint    plane_nrm[8][3];

    step_res_t expected_steps[$];
    int        fail_cnt = 0;
    int        idle_cnt = 0;
    bit        tx_free = 1'b0;
    bit        rx_free = 1'b0;
    bit        hold_req = 1'b0;
    int        hold_cnt = 0;
    int        stall_left = 0;
    string     field_name[9] = '{"new_pos_x", "new_pos_y", "new_pos_z",
                                 "new_vel_x", "new_vel_y", "new_vel_z",
                                 "new_acc_x", "new_acc_y", "new_acc_z"};

    particle_integrate_plane_bounce u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ---------------- Q16.16 step predictor ----------------
    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint t;
        t = a * b + 32768;
        return t >>> 16;
    endfunction

    function automatic longint qdot(longint ax, longint ay, longint az,
                                    longint bx, longint by, longint bz);
        return clip32(qmul(ax, bx) + qmul(ay, by) + qmul(az, bz));
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // writes a plane into the table or returns the updated particle; 1 if a result is due
    function automatic bit integrate_step(req_item_t it, output step_res_t res);
        longint          p[3], v[3], a[3], d[3];
        longint          rad, sdist, move, k, len;
        longint unsigned lsq, m;
        int              cnt, hits;
        rad  = it.rad;
        hits = 0;
        res  = '0;
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(it.p[i]);
            v[i] = $signed(it.v[i]);
            a[i] = $signed(it.a[i]);
        end
        if (it.kind == REQ_LD) begin
            for (int i = 0; i < 3; i++) begin
                plane_pt[it.slot][i]  = p[i];
                plane_nrm[it.slot][i] = v[i];
            end
            return 1'b0;
        end
        if (grav_on) begin
            a[1] = clip32(a[1] - qmul(longint'(pipb_pkg::Q_GRAVITY), dt_q));
            for (int i = 0; i < 3; i++) v[i] = clip32(v[i] + qmul(a[i], dt_q));
        end
        lsq = 0;
        for (int i = 0; i < 3; i++) begin
            m = (v[i] < 0) ? -v[i] : v[i];
            lsq += m * m;
        end
        if (lsq > pipb_pkg::VMAX_SQ) begin
            len = root64(lsq);
            for (int i = 0; i < 3; i++)
                v[i] = clip32(v[i] * longint'(pipb_pkg::Q_VMAX) / len);
        end
        for (int i = 0; i < 3; i++) p[i] = clip32(p[i] + qmul(v[i], dt_q));
        if (planes_on) begin
            cnt = (planes_used < 8) ? planes_used : 8;
            for (int j = 0; j < cnt; j++) begin
                for (int i = 0; i < 3; i++) d[i] = clip32(p[i] - plane_pt[j][i]);
                sdist = qdot(plane_nrm[j][0], plane_nrm[j][1], plane_nrm[j][2],
                             d[0], d[1], d[2]);
                if (sdist < rad) begin
                    move = clip32(rad - sdist + longint'(pipb_pkg::Q_EPS));
                    for (int i = 0; i < 3; i++)
                        p[i] = clip32(p[i] + qmul(plane_nrm[j][i], move));
                    k = clip32(2 * qdot(v[0], v[1], v[2], plane_nrm[j][0],
                                        plane_nrm[j][1], plane_nrm[j][2]));
                    for (int i = 0; i < 3; i++) begin
                        v[i] = clip32(v[i] - qmul(k, plane_nrm[j][i]));
                        v[i] = clip32(qmul(v[i], longint'(pipb_pkg::Q_DAMP)));
                    end
                    if (hits < 15) hits++;
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            res.pva[i*32 +: 32]     = p[i][31:0];
            res.pva[96 + i*32 +: 32]  = v[i][31:0];
            res.pva[192 + i*32 +: 32] = a[i][31:0];
        end
        res.hits = hits[pipb_pkg::HIT_W-1:0];
        return 1'b1;
    endfunction

    // ---------------- result side ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req || hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_req ? 400 : hold_cnt - 1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_free || $urandom_range(0, 99) < 75) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 3)
                                                      : $urandom_range(10, 40);
        end
    end

    always @(posedge aclk) begin
        step_res_t exp_r;
        step_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.pva  = m_tdata[287:0];
            got.hits = m_tdata[291:288];
            if (expected_steps.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_cnt++;
            end else begin
                exp_r = expected_steps.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got.pva[k*32 +: 32] !== exp_r.pva[k*32 +: 32]) begin
                        $error("%s expected %0d got %0d", field_name[k],
                               $signed(exp_r.pva[k*32 +: 32]),
                               $signed(got.pva[k*32 +: 32]));
                        fail_cnt++;
                    end
                if (got.hits !== exp_r.hits) begin
                    $error("planes_hit expected %0d got %0d", exp_r.hits, got.hits);
                    fail_cnt++;
                end
            end
        end
    end

    // no transfer on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WDOG_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_item(req_item_t it);
        step_res_t r;
        int        gap;
        gap = tx_free ? 0 : ($urandom_range(0, 99) < 60 ? 0 :
              ($urandom_range(0, 99) < 90 ? $urandom_range(1, 3) : $urandom_range(8, 30)));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {6'b0, it.rad, it.a, it.v, it.p, it.slot};
        do @(posedge aclk); while (!s_tready);
        if (integrate_step(it, r)) expected_steps.insert(expected_steps.size(), r);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (expected_steps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(pipb_pkg::cfg_idx_t idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[pipb_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            pipb_pkg::CFG_STEP_TIME:   dt_q = value & 32'h1FFFF;
            pipb_pkg::CFG_GRAVITY:     grav_on = value[0];
            pipb_pkg::CFG_PLANES:      planes_on = value[0];
            pipb_pkg::CFG_PLANE_COUNT: planes_used = value & 4'hF;
            default: ;
        endcase
    endtask

    task automatic set_regs(int st, int grav, int pl, int cnt);
        write_reg(pipb_pkg::CFG_STEP_TIME, st);
        write_reg(pipb_pkg::CFG_GRAVITY, grav);
        write_reg(pipb_pkg::CFG_PLANES, pl);
        write_reg(pipb_pkg::CFG_PLANE_COUNT, cnt);
    endtask

    function automatic pipb_pkg::q_t rnd_units(int span);
        return $signed($urandom_range(0, 2 * span * ONE)) - span * ONE;
    endfunction

    function automatic req_item_t mk_item(pipb_pkg::req_t kind, int slot,
                                          pipb_pkg::q_t px, pipb_pkg::q_t py,
                                          pipb_pkg::q_t pz, pipb_pkg::q_t vx,
                                          pipb_pkg::q_t vy, pipb_pkg::q_t vz,
                                          pipb_pkg::q_t ax, pipb_pkg::q_t ay,
                                          pipb_pkg::q_t az, int rad);
        req_item_t it;
        it.kind = kind;
        it.slot = slot[2:0];
        it.p[0] = px; it.p[1] = py; it.p[2] = pz;
        it.v[0] = vx; it.v[1] = vy; it.v[2] = vz;
        it.a[0] = ax; it.a[1] = ay; it.a[2] = az;
        it.rad  = rad[30:0];
        return it;
    endfunction

    // a particle in and around the box, sized so that walls are hit often
    function automatic req_item_t box_particle();
        return mk_item(REQ_PT, $urandom_range(0, 7),
                       rnd_units(12), rnd_units(12), rnd_units(12),
                       rnd_units(30), rnd_units(30), rnd_units(30),
                       rnd_units(20), rnd_units(20), rnd_units(20),
                       $urandom_range(0, 3 * ONE));
    endfunction

    function automatic req_item_t noise_item(pipb_pkg::req_t kind);
        req_item_t it;
        for (int i = 0; i < 3; i++) begin
            it.p[i] = $urandom;
            it.v[i] = $urandom;
            it.a[i] = $urandom;
        end
        it.kind = kind;
        it.slot = 3'($urandom_range(0, 7));
        it.rad  = 31'($urandom);
        return it;
    endfunction

    function automatic req_item_t axis_plane(int slot);
        pipb_pkg::q_t n[3];
        int           ax;
        n[0] = 0; n[1] = 0; n[2] = 0;
        ax = $urandom_range(0, 2);
        n[ax] = $urandom_range(0, 1) ? ONE : -ONE;
        return mk_item(REQ_LD, slot, -n[0] * 10, -n[1] * 10, -n[2] * 10,
                       n[0], n[1], n[2], 0, 0, 0, $urandom);
    endfunction

    task automatic random_run(int n_items);
        req_item_t it;
        int        r;
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) tx_free = ($urandom_range(0, 3) == 0);
            if (i % 50 == 25) rx_free = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 82)      it = box_particle();
            else if (r < 92) it = noise_item(REQ_PT);
            else if (r < 97) it = axis_plane($urandom_range(0, 7));
            else             it = noise_item(REQ_LD);
            send_item(it);
        end
        stop_sending();
        tx_free = 1'b0;
        rx_free = 1'b0;
    endtask

    // ---------------- tests ----------------
    task automatic test_plane_table();
        // box of side 20 round the origin, last slot unnormalised
        send_item(mk_item(REQ_LD, 0, 0, -10 * ONE, 0, 0, ONE, 0, 0, 0, 0, 0));
        send_item(mk_item(REQ_LD, 1, 0, 10 * ONE, 0, 0, -ONE, 0, 0, 0, 0, 0));
        send_item(mk_item(REQ_LD, 2, -10 * ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(REQ_LD, 3, 10 * ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(REQ_LD, 4, 0, 0, -10 * ONE, 0, 0, ONE, 0, 0, 0, 0));
        send_item(mk_item(REQ_LD, 5, 0, 0, 10 * ONE, 0, 0, -ONE, 0, 0, 0, 0));
        send_item(mk_item(REQ_LD, 6, 0, -12 * ONE, 0, 39322, 52429, 0, 0, 0, 0, 0));
        send_item(mk_item(REQ_LD, 7, 0, -11 * ONE, 0, 0, 3 * ONE, 0, 0, 0, 0, 0));
        stop_sending();
        wait_idle();
    endtask

    task automatic test_directed();
        pipb_pkg::q_t mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        set_regs(1092, 1, 1, 8);
        send_item(mk_item(REQ_PT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(REQ_PT, 7, mx, mx, mx, mx, mx, mx, mx, mx, mx, 32'h7FFF_FFFF));
        send_item(mk_item(REQ_PT, 0, mn, mn, mn, mn, mn, mn, mn, mn, mn, 0));
        // falling through the floor
        send_item(mk_item(REQ_PT, 0, ONE, -10 * ONE, 0, 0, -20 * ONE, 0, 0, 0, 0, ONE / 2));
        // corner: several walls at once
        send_item(mk_item(REQ_PT, 0, 9 * ONE, -9 * ONE, 9 * ONE,
                          5 * ONE, -5 * ONE, 5 * ONE, 0, 0, 0, 3 * ONE));
        // speed well above the clamp
        send_item(mk_item(REQ_PT, 0, 0, 0, 0, 40 * ONE, 30 * ONE, -20 * ONE,
                          0, 0, 0, ONE));
        stop_sending();
        wait_idle();
        // zero velocity stays zero without gravity; plane count past the table
        set_regs(1092, 0, 1, 15);
        send_item(mk_item(REQ_PT, 0, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, ONE));
        send_item(mk_item(REQ_PT, 0, 0, 0, 0, 0, 0, 0, mx, mn, mx, 32'h7FFF_FFFF));
        send_item(mk_item(REQ_PT, 0, 9 * ONE, 9 * ONE, 9 * ONE,
                          ONE, ONE, ONE, 0, 0, 0, 5 * ONE));
        stop_sending();
        wait_idle();
        // planes off, unit step and zero step
        set_regs(65536, 1, 0, 8);
        send_item(mk_item(REQ_PT, 0, 0, -10 * ONE, 0, 0, -ONE, 0, 0, 0, 0, ONE));
        send_item(mk_item(REQ_PT, 0, mx, mn, 0, mx, mn, 0, ONE, ONE, ONE, 0));
        stop_sending();
        wait_idle();
        write_reg(pipb_pkg::CFG_STEP_TIME, 0);
        send_item(mk_item(REQ_PT, 0, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                          ONE, ONE, ONE, ONE));
        send_item(mk_item(REQ_PT, 0, 0, 0, 0, 30 * ONE, 0, 0, 0, 0, 0, 0));
        stop_sending();
        wait_idle();
    endtask

    task automatic test_random_settings();
        int st[6]  = '{1092, 0, 65536, 1092, 3000, 20000};
        int gr[6]  = '{1, 1, 1, 0, 1, 0};
        int pl[6]  = '{1, 1, 1, 1, 0, 1};
        int cnt[6] = '{8, 8, 15, 4, 8, 0};
        for (int ph = 0; ph < 6; ph++) begin
            set_regs(st[ph], gr[ph], pl[ph], cnt[ph]);
            random_run(90);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        set_regs(4096, 1, 1, 8);
        tx_free = 1'b1;
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        random_run(120);
        wait_idle();
    endtask

    initial begin
        for (int j = 0; j < 8; j++)
            for (int i = 0; i < 3; i++) begin
                plane_pt[j][i]  = 0;
                plane_nrm[j][i] = 0;
            end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_plane_table();
        test_directed();
        test_random_settings();
        test_backpressure();
        repeat (DRAIN_CYC) @(posedge aclk);
        if (fail_cnt == 0 && expected_steps.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ particle_integrate_plane_bounce.f @@
+incdir+src
src/pipb_pkg.sv
src/pipb_clamp.sv
src/pipb_plane.sv
src/particle_integrate_plane_bounce.sv
bench/testbench.sv
